FILE: rtl/slcd_pkg.sv
// package for the sof/length/checksum deframer
// holds the frame constants and the result word type used by the core, the parser and the result register
package slcd_pkg;

  localparam logic [7:0]  START_BYTE        = 8'h7F;
  localparam logic [15:0] MIN_DATA_LEN      = 16'd2;
  localparam logic [15:0] MAX_DATA_LEN_RST  = 16'd1536;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] data_length;
    logic        last;
    logic        frame_ok;
  } result_t;

endpackage

FILE: rtl/slcd_rx_if.sv
// valid/ready channel carrying one received byte per word
// no dependencies
interface slcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/slcd_res_if.sv
// valid/ready channel carrying one data byte of a frame with its index and flags
// no dependencies
interface slcd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] data_length;
  logic        last;
  logic        frame_ok;

  modport source (output valid, output data_byte, output byte_index, output data_length,
                  output last, output frame_ok, input ready);
  modport sink   (input valid, input data_byte, input byte_index, input data_length,
                  input last, input frame_ok, output ready);
endinterface

FILE: rtl/slcd_cfg_if.sv
// valid/ready write channel for the maximum data length register
// no dependencies
interface slcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_data_length;

  modport source (output valid, output max_data_length, input ready);
  modport sink   (input valid, input max_data_length, output ready);
endinterface

FILE: rtl/sof_length_checksum_deframer_core.sv
// top level of the sof/length/checksum deframer
// depends on slcd_pkg, the channel interfaces, slcd_parser and slcd_out_reg
//
//  channel  dir  word                                             handshake
//  rx_i     in   rx_byte                                          valid/ready
//  res_o    out  data_byte, byte_index, data_length, last, ok     valid/ready
//  cfg_i    in   max_data_length                                  valid/ready, always ready
//
// one received byte per cycle while rx_i is not stalled; a data byte shows up on res_o in the cycle after it is taken
// header bytes produce no word on res_o
// rx_i stalls only while the result register is full and res_o is not ready
// reset clears the frame state and sets max_data_length to 1536
module sof_length_checksum_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  slcd_rx_if.sink    rx_i,
  slcd_res_if.source res_o,
  slcd_cfg_if.sink   cfg_i
);

  logic              accept;
  logic              in_ready;
  logic              res_valid;
  slcd_pkg::result_t res;
  logic [15:0]       max_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= slcd_pkg::MAX_DATA_LEN_RST;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_data_length;
    end
  end

  assign rx_i.ready = in_ready;
  assign accept     = rx_i.valid && in_ready;

  slcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slcd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .in_ready_o (in_ready),
    .res_o      (res_o)
  );

endmodule

FILE: rtl/slcd_parser.sv
// header/data parser: holds the frame state and builds one result word per data byte
// depends on slcd_pkg
module slcd_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [15:0]           max_len_i,
  output logic                  res_valid_o,
  output slcd_pkg::result_t     res_o
);

  typedef enum logic [1:0] {
    HDR_START  = 2'd0,
    HDR_LEN_HI = 2'd1,
    HDR_LEN_LO = 2'd2
  } hdr_pos_e;

  hdr_pos_e    hdr_pos_q, hdr_pos_d;
  logic        in_data_q, in_data_d;
  logic [7:0]  start_q, start_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] data_pos_q, data_pos_d;
  logic [7:0]  sum_q, sum_d;

  logic [15:0] hdr_len;
  logic        hdr_ok;
  logic [16:0] pos_inc;
  logic        is_last;

  assign hdr_len = {len_hi_q, rx_byte_i};
  assign hdr_ok  = (start_q == slcd_pkg::START_BYTE) && (hdr_len >= slcd_pkg::MIN_DATA_LEN)
                   && (hdr_len <= max_len_i);
  assign pos_inc = {1'b0, data_pos_q} + 17'd1;
  assign is_last = pos_inc >= {1'b0, frame_len_q};

  always_comb begin
    hdr_pos_d   = hdr_pos_q;
    in_data_d   = in_data_q;
    start_d     = start_q;
    len_hi_d    = len_hi_q;
    frame_len_d = frame_len_q;
    data_pos_d  = data_pos_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;

    res_o.data_byte   = rx_byte_i;
    res_o.byte_index  = data_pos_q;
    res_o.data_length = frame_len_q;
    res_o.last        = is_last;
    res_o.frame_ok    = is_last && ((sum_q + rx_byte_i) == 8'd0);

    if (accept_i) begin
      if (!in_data_q) begin
        case (hdr_pos_q)
          HDR_LEN_HI: begin
            len_hi_d  = rx_byte_i;
            hdr_pos_d = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            hdr_pos_d = HDR_START;
            if (hdr_ok) begin
              frame_len_d = hdr_len;
              data_pos_d  = 16'd0;
              sum_d       = start_q + len_hi_q + rx_byte_i;
              in_data_d   = 1'b1;
            end
          end
          default: begin
            // unused position code behaves like the start position
            start_d   = rx_byte_i;
            hdr_pos_d = HDR_LEN_HI;
          end
        endcase
      end else begin
        res_valid_o = 1'b1;
        sum_d       = sum_q + rx_byte_i;
        if (is_last) begin
          in_data_d  = 1'b0;
          hdr_pos_d  = HDR_START;
          data_pos_d = 16'd0;
        end else begin
          data_pos_d = pos_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= HDR_START;
      in_data_q   <= 1'b0;
      start_q     <= 8'd0;
      len_hi_q    <= 8'd0;
      frame_len_q <= 16'd0;
      data_pos_q  <= 16'd0;
      sum_q       <= 8'd0;
    end else begin
      hdr_pos_q   <= hdr_pos_d;
      in_data_q   <= in_data_d;
      start_q     <= start_d;
      len_hi_q    <= len_hi_d;
      frame_len_q <= frame_len_d;
      data_pos_q  <= data_pos_d;
      sum_q       <= sum_d;
    end
  end

endmodule

FILE: rtl/slcd_out_reg.sv
// result register: holds one result word until the sink takes it
// depends on slcd_pkg and slcd_res_if
module slcd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  slcd_pkg::result_t in_data_i,
  output logic              in_ready_o,
  slcd_res_if.source        res_o
);

  logic              valid_q, valid_d;
  slcd_pkg::result_t data_q, data_d;
  logic              load;

  // a new word may enter when the register is empty or being drained
  assign in_ready_o = !valid_q || res_o.ready;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = in_data_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign res_o.valid       = valid_q;
  assign res_o.data_byte   = data_q.data_byte;
  assign res_o.byte_index  = data_q.byte_index;
  assign res_o.data_length = data_q.data_length;
  assign res_o.last        = data_q.last;
  assign res_o.frame_ok    = data_q.frame_ok;

endmodule

FILE: dv/tb_sof_length_checksum_deframer_core.sv
`timescale 1ns / 100ps
// testbench for sof_length_checksum_deframer_core: sends framed and broken byte streams,
// predicts every data word and its flags, and checks them in order against res_o
// depends on slcd_pkg and the rx, res and cfg channel interfaces
module tb_sof_length_checksum_deframer_core;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 4;
  localparam int LONG_HOLD   = 300;

  // header position while collecting a header block
  localparam logic [1:0] HDR_SOF    = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;

  logic clk_i = 1'b0;
  logic rst_ni;

  slcd_rx_if  rx ();
  slcd_res_if res ();
  slcd_cfg_if cfg ();

  sof_length_checksum_deframer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] cfg_max_len;
  logic        in_frame;
  logic [1:0]  hdr_pos;
  logic [7:0]  sof_seen;
  logic [7:0]  len_hi_seen;
  logic [15:0] frame_len;
  logic [15:0] data_pos;
  logic [7:0]  frame_sum;

  slcd_pkg::result_t data_words_q[$];

  int mismatch_cnt = 0;
  int rx_words_sent = 0;
  int stall_cycles = 0;
  int rx_gap_pct = 0;
  int res_stall_pct = 0;
  int res_hold_cycles = 0;

  function automatic void deframe_byte(input logic [7:0] b);
    slcd_pkg::result_t w;
    logic [15:0]       len;
    len = {len_hi_seen, b};
    if (!in_frame) begin
      case (hdr_pos)
        HDR_LEN_HI: begin
          len_hi_seen = b;
          hdr_pos = HDR_LEN_LO;
        end
        HDR_LEN_LO: begin
          hdr_pos = HDR_SOF;
          if (sof_seen == slcd_pkg::START_BYTE && len >= slcd_pkg::MIN_DATA_LEN &&
              len <= cfg_max_len) begin
            frame_len = len;
            data_pos = '0;
            frame_sum = sof_seen + len_hi_seen + b;
            in_frame = 1'b1;
          end
        end
        default: begin
          sof_seen = b;
          hdr_pos = HDR_LEN_HI;
        end
      endcase
    end else begin
      frame_sum = frame_sum + b;
      w.data_byte = b;
      w.byte_index = data_pos;
      w.data_length = frame_len;
      w.last = ({1'b0, data_pos} + 17'd1) >= {1'b0, frame_len};
      w.frame_ok = w.last && (frame_sum == 8'd0);
      data_words_q.push_back(w);
      if (w.last) begin
        in_frame = 1'b0;
        hdr_pos = HDR_SOF;
        data_pos = '0;
      end else begin
        data_pos = data_pos + 16'd1;
      end
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    slcd_pkg::result_t w;
    if (rst_ni && res.valid && res.ready) begin
      if (data_words_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected data word: byte %02h idx %0d len %0d last %0b ok %0b",
                   res.data_byte, res.byte_index, res.data_length, res.last, res.frame_ok);
      end else begin
        w = data_words_q.pop_front();
        if (res.data_byte !== w.data_byte || res.byte_index !== w.byte_index ||
            res.data_length !== w.data_length || res.last !== w.last ||
            res.frame_ok !== w.frame_ok) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"mismatch: exp byte %02h idx %0d len %0d last %0b ok %0b",
                      " / got byte %02h idx %0d len %0d last %0b ok %0b"},
                     w.data_byte, w.byte_index, w.data_length, w.last, w.frame_ok,
                     res.data_byte, res.byte_index, res.data_length, res.last,
                     res.frame_ok);
        end
      end
    end
  end

  // receiver: random stall bursts, plus a long hold when a test asks for one
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_hold_cycles != 0) begin
        res.ready <= 1'b0;
        repeat (res_hold_cycles) @(posedge clk_i);
        res_hold_cycles = 0;
        res.ready <= 1'b1;
      end else if (res_stall_pct != 0 && $urandom_range(1, 100) <= res_stall_pct) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb_sof_length_checksum_deframer_core: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (rx_gap_pct != 0 && $urandom_range(1, 100) <= rx_gap_pct) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    deframe_byte(b);
    rx_words_sent++;
  endtask

  // header then n_data bytes; the final byte is the checksum, forced good or bad
  task automatic send_frame(input logic [7:0] sof, input logic [15:0] len,
                            input int n_data, input int fill, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = sof + len[15:8] + len[7:0];
    send_byte(sof);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < n_data; i++) begin
      if (fill >= 0) b = fill[7:0];
      else b = 8'($urandom_range(0, 255));
      if (i == n_data - 1) begin
        if (good_sum) b = 8'd0 - sum;
        else if (8'(sum + b) == 8'd0) b = b + 8'd1;
      end
      sum = sum + b;
      send_byte(b);
    end
  endtask

  task automatic wait_frames_drained();
    rx.valid <= 1'b0;
    while (data_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    wait_frames_drained();
    cfg.valid <= 1'b1;
    cfg.max_data_length <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg_max_len = v;
    cfg.valid <= 1'b0;
  endtask

  task automatic test_reset_max();
    // one above the reset maximum is dropped, then a minimal frame passes
    send_frame(slcd_pkg::START_BYTE, 16'd1537, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, slcd_pkg::MIN_DATA_LEN, 2, 0, 1'b1);
  endtask

  task automatic test_header_rejects();
    write_max_len(16'd5);
    send_frame(8'h7E, 16'd2, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, 16'd0, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, 16'd1, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, 16'd6, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, 16'd5, 5, 255, 1'b1);
    send_frame(slcd_pkg::START_BYTE, 16'd2, 2, 0, 1'b0);
  endtask

  task automatic test_small_max();
    // below the minimum length nothing can get through
    write_max_len(16'd0);
    send_frame(slcd_pkg::START_BYTE, 16'd2, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, 16'd0, 0, -1, 1'b0);
    write_max_len(16'd1);
    send_frame(slcd_pkg::START_BYTE, 16'd1, 0, -1, 1'b0);
    send_frame(slcd_pkg::START_BYTE, 16'd2, 0, -1, 1'b0);
  endtask

  task automatic test_backpressure();
    write_max_len(slcd_pkg::MAX_DATA_LEN_RST);
    rx_gap_pct = 0;
    res_stall_pct = 0;
    res_hold_cycles = LONG_HOLD;
    repeat (4) send_frame(slcd_pkg::START_BYTE, 16'd10, 10, -1, 1'b1);
    wait_frames_drained();
  endtask

  task automatic test_random_traffic(input int n_words, input bit with_idle);
    int         stop_at;
    int         pick;
    int         len;
    int         cap;
    logic [7:0] sof;
    stop_at = rx_words_sent + n_words;
    cap = (cfg_max_len < 16'd24) ? int'(cfg_max_len) : 24;
    while (rx_words_sent < stop_at) begin
      if (with_idle && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: rx_gap_pct = 0;
          1: rx_gap_pct = 4;
          default: rx_gap_pct = 12;
        endcase
        case ($urandom_range(0, 2))
          0: res_stall_pct = 0;
          1: res_stall_pct = 4;
          default: res_stall_pct = 12;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 15) == 0 && cfg_max_len <= 16'd400) len = int'(cfg_max_len);
        else len = $urandom_range(2, cap);
        send_frame(slcd_pkg::START_BYTE, 16'(len), len, -1, $urandom_range(0, 3) != 0);
      end else if (pick < 78) begin
        sof = 8'($urandom_range(0, 254));
        if (sof >= slcd_pkg::START_BYTE) sof = sof + 8'd1;
        send_frame(sof, 16'($urandom_range(2, cap)), 0, -1, 1'b0);
      end else if (pick < 88) begin
        if (cfg_max_len != 16'hFFFF) len = $urandom_range(int'(cfg_max_len) + 1, 65535);
        else len = $urandom_range(0, 1);
        send_frame(slcd_pkg::START_BYTE, 16'(len), 0, -1, 1'b0);
      end else if (pick < 94) begin
        send_frame(slcd_pkg::START_BYTE, 16'($urandom_range(0, 1)), 0, -1, 1'b0);
      end else if (pick < 97) begin
        repeat (3) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // truncated frame, the next bytes get swallowed as its data
        len = $urandom_range(2, cap);
        send_frame(slcd_pkg::START_BYTE, 16'(len), $urandom_range(0, len - 1), -1, 1'b0);
      end
    end
  endtask

  task automatic test_random_settings();
    write_max_len(16'd2);
    test_random_traffic(170, 1'b1);
    write_max_len(slcd_pkg::MAX_DATA_LEN_RST);
    test_random_traffic(170, 1'b1);
    write_max_len(16'd7);
    test_random_traffic(170, 1'b1);
    write_max_len(16'($urandom_range(3, 60)));
    test_random_traffic(170, 1'b1);
    write_max_len(16'hFFFF);
    test_random_traffic(170, 1'b1);
    write_max_len(16'd300);
    test_random_traffic(170, 1'b1);
  endtask

  task automatic test_largest_frame();
    // a frame exactly at the configured maximum
    rx_gap_pct = 0;
    res_stall_pct = 0;
    write_max_len(16'd64);
    send_frame(slcd_pkg::START_BYTE, 16'd64, 64, -1, 1'b1);
    test_random_traffic(60, 1'b0);
  endtask

  initial begin
    rst_ni <= 1'b0;
    rx.valid <= 1'b0;
    rx.rx_byte <= 8'h00;
    cfg.valid <= 1'b0;
    cfg.max_data_length <= 16'h0000;
    cfg_max_len = slcd_pkg::MAX_DATA_LEN_RST;
    in_frame = 1'b0;
    hdr_pos = HDR_SOF;
    sof_seen = '0;
    len_hi_seen = '0;
    frame_len = '0;
    data_pos = '0;
    frame_sum = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_max();
    test_header_rejects();
    test_small_max();
    test_backpressure();
    test_random_settings();
    test_largest_frame();

    wait_frames_drained();
    if (mismatch_cnt == 0 && data_words_q.size() == 0) begin
      $display("tb_sof_length_checksum_deframer_core: done, clean");
    end else begin
      $display("tb_sof_length_checksum_deframer_core: done, errors");
    end
    $finish;
  end

endmodule
